FILE: hw/rtl/arpc_pkg.sv
// Shared types and codes for the address cache.
`timescale 1ns / 1ps
package arpc_pkg;
   typedef enum logic [2:0] {
      FUNC_LOOKUP = 3'd0, FUNC_QUEUE = 3'd1, FUNC_INSERT = 3'd2,
      FUNC_REMOVE = 3'd3, FUNC_TICK = 3'd4, FUNC_CLEAR = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      KIND_HIT = 4'd0, KIND_MISS = 4'd1, KIND_QNEW = 4'd2, KIND_QOLD = 4'd3,
      KIND_RFULL = 4'd4, KIND_INS_WAIT = 4'd5, KIND_INS_NONE = 4'd6,
      KIND_CFULL = 4'd7, KIND_SEND = 4'd8, KIND_FAIL = 4'd9,
      KIND_TICK = 4'd10, KIND_REMOVED = 4'd11, KIND_CLEARED = 4'd12
   } kind_type;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] ip;
      logic [47:0] mac;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] addr_ip;
      logic [47:0] addr_mac;
      logic [7:0]  tries;
      logic [15:0] pending_packets;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout;
      logic [7:0]  max_tries;
      logic [7:0]  retry;
   } cfg_type;
endpackage

FILE: hw/rtl/arpc_if.sv
// Valid/ready channel carrying one word.
`timescale 1ns / 1ps
interface arpc_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

FILE: hw/rtl/arp_cache_with_retry.sv
// Top level of the address cache with request retry.
`timescale 1ns / 1ps
// Usage: the req channel carries one command word (func, ip, mac); the rsp
// channel returns result words, the final one of each command with last set.
// Configuration is written through csr_write/csr_index/csr_data while idle.
// Sequence: a lookup walks the cache, then responds; queue and remove walk
// the request table; insert walks both; a tick walks the cache, then the
// request table one slot a cycle, pausing while a result word is waiting.
// Clear answers straight from idle with a registered result word. Unused
// func codes give no result.
// Reset clears both valid vectors and loads the default configuration.
// A stalled receiver holds the result word; no new command is taken until
// every result of the current one has been taken.
module arp_cache_with_retry #(
   parameter int CACHE_DEPTH = 32,
   parameter int REQUEST_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0] csr_data,
   arpc_if.sink                            req,
   arpc_if.source                          rsp
);
   import arpc_pkg::*;
   cfg_type cfg;
   arpc_csr u_csr (.clock, .reset, .csr_write, .csr_index, .csr_data, .cfg);
   arpc_engine #(.CACHE_DEPTH(CACHE_DEPTH), .REQUEST_DEPTH(REQUEST_DEPTH)) u_eng (
      .clock, .reset, .cfg, .req, .rsp);
endmodule

FILE: hw/rtl/arpc_csr.sv
// Configuration registers.
`timescale 1ns / 1ps
module arpc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0] csr_data,
   output arpc_pkg::cfg_type               cfg
);
   import arpc_pkg::*;
   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{timeout: 16'd30, max_tries: 8'd5, retry: 8'd1};
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIMEOUT:   cfg_ff.timeout <= csr_data;
            CSR_MAX_TRIES: cfg_ff.max_tries <= csr_data[7:0];
            CSR_RETRY:     cfg_ff.retry <= csr_data[7:0];
            default:       ;
         endcase
      end
   end
   assign cfg = cfg_ff;
endmodule

FILE: hw/rtl/arpc_engine.sv
// Walks both tables one slot a cycle; a tick walk pauses while a result waits.
`timescale 1ns / 1ps
module arpc_engine #(
   parameter int CACHE_DEPTH = 32,
   parameter int REQUEST_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  arpc_pkg::cfg_type cfg,
   arpc_if.sink              req,
   arpc_if.source            rsp
);
   import arpc_pkg::*;
   localparam int CW = $clog2(CACHE_DEPTH);
   localparam int RW = $clog2(REQUEST_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_CSCAN = 6'b000010, S_RSCAN = 6'b000100,
      S_DECIDE = 6'b001000, S_OUT = 6'b010000, S_TICKR = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // cache memory
   logic [31:0] e_ip [CACHE_DEPTH];
   logic [47:0] e_mac [CACHE_DEPTH];
   logic [15:0] e_age [CACHE_DEPTH];
   logic [CACHE_DEPTH-1:0] e_valid_ff;
   // request table
   logic [31:0] r_ip [REQUEST_DEPTH];
   logic        r_sent [REQUEST_DEPTH];
   logic [7:0]  r_tries [REQUEST_DEPTH];
   logic [7:0]  r_since [REQUEST_DEPTH];
   logic [15:0] r_pkts [REQUEST_DEPTH];
   logic [REQUEST_DEPTH-1:0] r_valid_ff;

   req_type     cur_ff;
   logic [CW:0] ci_ff;
   logic [RW:0] ri_ff;
   logic        ehit_ff, efree_ok_ff, rhit_ff, rfree_ok_ff;
   logic [CW-1:0] eidx_ff, efree_ff;
   logic [RW-1:0] ridx_ff, rfree_ff;
   logic [47:0] hmac_ff;
   logic        any_ff;
   rsp_type     out_ff;
   logic        ov_ff;

   wire [CW-1:0] ci = ci_ff[CW-1:0];
   wire [RW-1:0] ri = ri_ff[RW-1:0];
   wire accept = req.valid && req.ready;
   wire take = rsp.valid && rsp.ready;

   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.word = out_ff;

   // compare logic: the current slot of each table against the command address
   wire c_match = e_valid_ff[ci] && (e_ip[ci] == cur_ff.ip);
   wire r_match = r_valid_ff[ri] && (r_ip[ri] == cur_ff.ip);
   wire [15:0] age_n = (e_age[ci] == 16'hFFFF) ? e_age[ci] : e_age[ci] + 16'd1;
   wire [7:0] since_n = (r_since[ri] == 8'hFF) ? r_since[ri] : r_since[ri] + 8'd1;
   wire r_due = !r_sent[ri] || (since_n >= cfg.retry);
   wire [7:0] tries_n = (r_tries[ri] == 8'hFF) ? r_tries[ri] : r_tries[ri] + 8'd1;
   wire [15:0] pk = r_pkts[ridx_ff];
   wire [15:0] pk_n = (pk == 16'hFFFF) ? pk : pk + 16'd1;

   function automatic rsp_type mk(kind_type k, logic [31:0] a, logic [47:0] m,
                                  logic [7:0] t, logic [15:0] p, logic l);
      rsp_type o;
      o = '{kind: k, addr_ip: a, addr_mac: m, tries: t, pending_packets: p,
            last: l};
      return o;
   endfunction

   // bit k is set when slot k will be due this tick (state of later slots is
   // still untouched, so the due test is evaluated on them directly)
   logic [REQUEST_DEPTH-1:0] later_due;
   always_comb begin
      for (int k = 0; k < REQUEST_DEPTH; k++) begin
         later_due[k] = r_valid_ff[k] && (!r_sent[k] ||
            (((r_since[k] == 8'hFF) ? r_since[k] : r_since[k] + 8'd1) >= cfg.retry));
      end
   end

   function automatic logic last_due(logic [RW:0] pos);
      logic any;
      any = 1'b0;
      for (int k = 0; k < REQUEST_DEPTH; k++)
         if ((RW+1)'(k) > pos && later_due[k]) any = 1'b1;
      return !any;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (req.word.func)
               FUNC_LOOKUP, FUNC_INSERT, FUNC_TICK: state_in = S_CSCAN;
               FUNC_QUEUE, FUNC_REMOVE: state_in = S_RSCAN;
               FUNC_CLEAR: state_in = S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_CSCAN: if (ci_ff == CW'(CACHE_DEPTH - 1) + (CW+1)'(0)) begin
            state_in = (cur_ff.func == FUNC_TICK) ? S_TICKR :
                       (cur_ff.func == FUNC_LOOKUP) ? S_DECIDE : S_RSCAN;
         end
         S_RSCAN: if (ri_ff == (RW+1)'(REQUEST_DEPTH - 1)) state_in = S_DECIDE;
         S_DECIDE: state_in = S_OUT;
         S_OUT: if (!ov_ff) state_in = S_IDLE;
         S_TICKR: if (!ov_ff && ri_ff == (RW+1)'(REQUEST_DEPTH)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         e_valid_ff <= '0;
         r_valid_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (take) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept) begin
               cur_ff <= req.word;
               ci_ff <= '0;
               ri_ff <= '0;
               ehit_ff <= 1'b0; efree_ok_ff <= 1'b0;
               rhit_ff <= 1'b0; rfree_ok_ff <= 1'b0;
               any_ff <= 1'b0;
               if (req.word.func == FUNC_CLEAR) begin
                  e_valid_ff <= '0;
                  r_valid_ff <= '0;
                  out_ff <= mk(KIND_CLEARED, '0, '0, '0, '0, 1'b1);
                  ov_ff <= 1'b1;
               end
            end
            S_CSCAN: begin
               ci_ff <= ci_ff + 1'b1;
               if (cur_ff.func == FUNC_TICK) begin
                  if (e_valid_ff[ci]) begin
                     e_age[ci] <= age_n;
                     if (age_n > cfg.timeout) e_valid_ff[ci] <= 1'b0;
                  end
               end else begin
                  if (c_match && !ehit_ff) begin
                     ehit_ff <= 1'b1; eidx_ff <= ci; hmac_ff <= e_mac[ci];
                  end
                  if (!e_valid_ff[ci] && !efree_ok_ff) begin
                     efree_ok_ff <= 1'b1; efree_ff <= ci;
                  end
               end
            end
            S_RSCAN: begin
               ri_ff <= ri_ff + 1'b1;
               if (r_match && !rhit_ff) begin
                  rhit_ff <= 1'b1; ridx_ff <= ri;
               end
               if (!r_valid_ff[ri] && !rfree_ok_ff) begin
                  rfree_ok_ff <= 1'b1; rfree_ff <= ri;
               end
            end
            S_DECIDE: begin
               ov_ff <= 1'b1;
               case (cur_ff.func)
                  FUNC_LOOKUP: out_ff <= ehit_ff ?
                     mk(KIND_HIT, cur_ff.ip, hmac_ff, '0, '0, 1'b1) :
                     mk(KIND_MISS, cur_ff.ip, '0, '0, '0, 1'b1);
                  FUNC_QUEUE: begin
                     if (rhit_ff) begin
                        r_pkts[ridx_ff] <= pk_n;
                        out_ff <= mk(KIND_QOLD, cur_ff.ip, '0, r_tries[ridx_ff],
                                     pk_n, 1'b1);
                     end else if (!rfree_ok_ff) begin
                        out_ff <= mk(KIND_RFULL, cur_ff.ip, '0, '0, '0, 1'b1);
                     end else begin
                        r_valid_ff[rfree_ff] <= 1'b1;
                        r_ip[rfree_ff] <= cur_ff.ip;
                        r_sent[rfree_ff] <= 1'b0;
                        r_tries[rfree_ff] <= '0;
                        r_since[rfree_ff] <= '0;
                        r_pkts[rfree_ff] <= 16'd1;
                        out_ff <= mk(KIND_QNEW, cur_ff.ip, '0, '0, 16'd1, 1'b1);
                     end
                  end
                  FUNC_INSERT: begin
                     if (!ehit_ff && !efree_ok_ff) begin
                        out_ff <= mk(KIND_CFULL, cur_ff.ip, '0, '0, '0, 1'b1);
                     end else begin
                        e_valid_ff[ehit_ff ? eidx_ff : efree_ff] <= 1'b1;
                        e_ip[ehit_ff ? eidx_ff : efree_ff] <= cur_ff.ip;
                        e_mac[ehit_ff ? eidx_ff : efree_ff] <= cur_ff.mac;
                        e_age[ehit_ff ? eidx_ff : efree_ff] <= '0;
                        out_ff <= rhit_ff ?
                           mk(KIND_INS_WAIT, cur_ff.ip, '0, r_tries[ridx_ff], pk, 1'b1) :
                           mk(KIND_INS_NONE, cur_ff.ip, '0, '0, '0, 1'b1);
                     end
                  end
                  default: begin
                     if (rhit_ff) r_valid_ff[ridx_ff] <= 1'b0;
                     out_ff <= rhit_ff ?
                        mk(KIND_REMOVED, cur_ff.ip, '0, r_tries[ridx_ff], pk, 1'b1) :
                        mk(KIND_REMOVED, cur_ff.ip, '0, '0, '0, 1'b1);
                  end
               endcase
            end
            S_TICKR: if (!ov_ff) begin
               if (ri_ff == (RW+1)'(REQUEST_DEPTH)) begin
                  if (!any_ff) begin
                     out_ff <= mk(KIND_TICK, '0, '0, '0, '0, 1'b1);
                     ov_ff <= 1'b1;
                  end
               end else begin
                  ri_ff <= ri_ff + 1'b1;
                  if (r_valid_ff[ri]) begin
                     if (!r_due) begin
                        if (r_sent[ri]) r_since[ri] <= since_n;
                     end else begin
                        any_ff <= 1'b1;
                        ov_ff <= 1'b1;
                        if (r_tries[ri] >= cfg.max_tries) begin
                           r_valid_ff[ri] <= 1'b0;
                           out_ff <= mk(KIND_FAIL, r_ip[ri], '0, r_tries[ri],
                                        r_pkts[ri], last_due(ri_ff));
                        end else begin
                           r_tries[ri] <= tries_n;
                           r_since[ri] <= '0;
                           r_sent[ri] <= 1'b1;
                           out_ff <= mk(KIND_SEND, r_ip[ri], '0, tries_n,
                                        r_pkts[ri], last_due(ri_ff));
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.word))
      else $error("result dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !req.ready) else $error("accept while result pending");
endmodule

FILE: sim/tb_arp_cache_with_retry.sv
// Testbench for arp_cache_with_retry: directed table, then random traffic checked by a predictor.
`timescale 1ns / 1ps
module tb_arp_cache_with_retry;
   import arpc_pkg::*;

   localparam int CACHE_SLOTS   = 32;
   localparam int REQUEST_SLOTS = 16;
   // func codes the block ignores
   localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_B = 3'd7;
   // a command walks ~CACHE+REQUEST slots; allow plenty of slack
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 400;
   localparam int IP_POOL      = 48;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   arpc_if #(.word_type(req_type)) req_ch ();
   arpc_if #(.word_type(rsp_type)) rsp_ch ();

   arp_cache_with_retry i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source)
   );

   // ---------------------------------------------------------------
   // Shadow of the block: configuration and both tables
   // ---------------------------------------------------------------
   logic [15:0] timeout_ticks;
   logic [7:0]  try_limit;
   logic [7:0]  retry_ticks;

   bit          cache_valid [CACHE_SLOTS];
   logic [31:0] cache_ip    [CACHE_SLOTS];
   logic [47:0] cache_mac   [CACHE_SLOTS];
   logic [15:0] cache_age   [CACHE_SLOTS];

   bit          pend_valid  [REQUEST_SLOTS];
   logic [31:0] pend_ip     [REQUEST_SLOTS];
   bit          pend_sent   [REQUEST_SLOTS];
   logic [7:0]  pend_tries  [REQUEST_SLOTS];
   logic [7:0]  pend_since  [REQUEST_SLOTS];
   logic [15:0] pend_pkts   [REQUEST_SLOTS];

   rsp_type     words_due[$];   // result words still to come, oldest first
   int          errors = 0;
   int          cycles = 0;
   int          long_hold_req;  // bumped by stimulus, served by the receiver
   logic [31:0] ip_pool [IP_POOL];

   function automatic rsp_type rsp_word(kind_type k, logic [31:0] ip, logic [47:0] mac,
                                        logic [7:0] t, logic [15:0] p, logic l);
      rsp_type w;
      w.kind = k;
      w.addr_ip = ip;
      w.addr_mac = mac;
      w.tries = t;
      w.pending_packets = p;
      w.last = l;
      return w;
   endfunction

   // appends one expected word at the tail
   function automatic void expect_word(rsp_type w);
      words_due = {words_due, w};
   endfunction

   function automatic int cache_slot_of(logic [31:0] ip);
      for (int i = 0; i < CACHE_SLOTS; i++)
         if (cache_valid[i] && cache_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic int pend_slot_of(logic [31:0] ip);
      for (int i = 0; i < REQUEST_SLOTS; i++)
         if (pend_valid[i] && pend_ip[i] == ip) return i;
      return -1;
   endfunction

   // Updates the shadow tables for one command and queues its result words.
   task automatic arp_predict(req_type w);
      int e;
      int r;
      int n;
      bit due;
      n = 0;
      case (w.func)
         FUNC_LOOKUP: begin
            e = cache_slot_of(w.ip);
            if (e >= 0) expect_word(rsp_word(KIND_HIT, w.ip, cache_mac[e], '0, '0, 1'b1));
            else expect_word(rsp_word(KIND_MISS, w.ip, '0, '0, '0, 1'b1));
         end
         FUNC_QUEUE: begin
            r = pend_slot_of(w.ip);
            if (r >= 0) begin
               if (pend_pkts[r] != 16'hFFFF) pend_pkts[r]++;
               expect_word(rsp_word(KIND_QOLD, w.ip, '0, pend_tries[r], pend_pkts[r], 1'b1));
            end else begin
               r = -1;
               for (int i = REQUEST_SLOTS - 1; i >= 0; i--)
                  if (!pend_valid[i]) r = i;
               if (r < 0) begin
                  expect_word(rsp_word(KIND_RFULL, w.ip, '0, '0, '0, 1'b1));
               end else begin
                  pend_valid[r] = 1'b1;
                  pend_ip[r] = w.ip;
                  pend_sent[r] = 1'b0;
                  pend_tries[r] = '0;
                  pend_since[r] = '0;
                  pend_pkts[r] = 16'd1;
                  expect_word(rsp_word(KIND_QNEW, w.ip, '0, '0, 16'd1, 1'b1));
               end
            end
         end
         FUNC_INSERT: begin
            e = cache_slot_of(w.ip);
            if (e < 0)
               for (int i = CACHE_SLOTS - 1; i >= 0; i--)
                  if (!cache_valid[i]) e = i;
            if (e < 0) begin
               expect_word(rsp_word(KIND_CFULL, w.ip, '0, '0, '0, 1'b1));
            end else begin
               cache_valid[e] = 1'b1;
               cache_ip[e] = w.ip;
               cache_mac[e] = w.mac;
               cache_age[e] = '0;
               r = pend_slot_of(w.ip);
               if (r >= 0)
                  expect_word(rsp_word(KIND_INS_WAIT, w.ip, '0, pend_tries[r],
                                       pend_pkts[r], 1'b1));
               else
                  expect_word(rsp_word(KIND_INS_NONE, w.ip, '0, '0, '0, 1'b1));
            end
         end
         FUNC_REMOVE: begin
            r = pend_slot_of(w.ip);
            if (r >= 0) begin
               expect_word(rsp_word(KIND_REMOVED, w.ip, '0, pend_tries[r],
                                    pend_pkts[r], 1'b1));
               pend_valid[r] = 1'b0;
            end else begin
               expect_word(rsp_word(KIND_REMOVED, w.ip, '0, '0, '0, 1'b1));
            end
         end
         FUNC_TICK: begin
            // age the cache, dropping entries past the timeout
            for (int i = 0; i < CACHE_SLOTS; i++) begin
               if (cache_valid[i]) begin
                  if (cache_age[i] != 16'hFFFF) cache_age[i]++;
                  if (cache_age[i] > timeout_ticks) cache_valid[i] = 1'b0;
               end
            end
            // then each due request sends again or gives up, in slot order
            for (int i = 0; i < REQUEST_SLOTS; i++) begin
               if (pend_valid[i]) begin
                  if (!pend_sent[i]) begin
                     due = 1'b1;
                  end else begin
                     if (pend_since[i] != 8'hFF) pend_since[i]++;
                     due = pend_since[i] >= retry_ticks;
                  end
                  if (due) begin
                     if (pend_tries[i] >= try_limit) begin
                        expect_word(rsp_word(KIND_FAIL, pend_ip[i], '0, pend_tries[i],
                                             pend_pkts[i], 1'b0));
                        pend_valid[i] = 1'b0;
                     end else begin
                        if (pend_tries[i] != 8'hFF) pend_tries[i]++;
                        pend_since[i] = '0;
                        pend_sent[i] = 1'b1;
                        expect_word(rsp_word(KIND_SEND, pend_ip[i], '0, pend_tries[i],
                                             pend_pkts[i], 1'b0));
                     end
                     n++;
                  end
               end
            end
            if (n == 0) expect_word(rsp_word(KIND_TICK, '0, '0, '0, '0, 1'b1));
            else words_due[words_due.size() - 1].last = 1'b1;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < CACHE_SLOTS; i++) cache_valid[i] = 1'b0;
            for (int i = 0; i < REQUEST_SLOTS; i++) pend_valid[i] = 1'b0;
            expect_word(rsp_word(KIND_CLEARED, '0, '0, '0, '0, 1'b1));
         end
         default: ;   // ignored codes: no state change, no word
      endcase
   endtask

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // ---------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, words_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Result checker: every accepted word against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.word;
         if (words_due.size() == 0) begin
            report($sformatf("unexpected word kind %0d ip %h", got.kind, got.addr_ip));
         end else begin
            want = words_due.pop_front();
            if (got.kind != want.kind)
               report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.addr_ip != want.addr_ip)
               report($sformatf("addr_ip %h, want %h", got.addr_ip, want.addr_ip));
            if (got.addr_mac != want.addr_mac)
               report($sformatf("addr_mac %h, want %h", got.addr_mac, want.addr_mac));
            if (got.tries != want.tries)
               report($sformatf("tries %0d, want %0d", got.tries, want.tries));
            if (got.pending_packets != want.pending_packets)
               report($sformatf("pending_packets %0d, want %0d",
                                got.pending_packets, want.pending_packets));
            if (got.last != want.last)
               report($sformatf("last %0b, want %0b", got.last, want.last));
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: stall pattern redrawn from four modes; long hold on request
   // ---------------------------------------------------------------
   initial begin
      int hold_left;
      int seen_hold;
      int mode;
      int mode_left;
      hold_left = 0;
      seen_hold = 0;
      mode = 0;
      mode_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req != seen_hold) begin
            seen_hold = long_hold_req;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = 50;
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready = 1'b1;                           // no stalls
               1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready = ($urandom_range(0, 9) < 3);
               default: rsp_ch.ready = ((cycles % 4) < 2);       // regular on/off
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender helpers
   // ---------------------------------------------------------------
   int burst_left;
   bit gaps_on;

   // Offers one word (called at a falling edge) and returns at the next falling edge
   // after acceptance. When typed is set, want replaces the last predicted word.
   task automatic send_word(req_type w, bit typed, rsp_type want);
      int g;
      if (burst_left == 0) begin
         g = gaps_on ? $urandom_range(0, 6) : 0;
         if (g > 0) begin
            req_ch.valid = 1'b0;
            repeat (g) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.word = w;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      arp_predict(w);
      if (typed) begin
         void'(words_due.pop_back());
         expect_word(want);
      end
      @(negedge clock);
   endtask

   task automatic idle_until_drained();
      req_ch.valid = 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      // extra settling time after the last expected word
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_TIMEOUT:   timeout_ticks = val;
         CSR_MAX_TRIES: try_limit = val[7:0];
         CSR_RETRY:     retry_ticks = val[7:0];
         default: ;
      endcase
   endtask

   function automatic req_type make_req(logic [2:0] f, logic [31:0] ip, logic [47:0] mac);
      req_type w;
      w.func = f;
      w.ip = ip;
      w.mac = mac;
      return w;
   endfunction

   function automatic logic [47:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return ip_pool[$urandom_range(0, IP_POOL - 1)];
   endfunction

   function automatic req_type rand_req();
      int p;
      logic [2:0] f;
      p = $urandom_range(0, 99);
      if (p < 20) f = FUNC_LOOKUP;
      else if (p < 42) f = FUNC_QUEUE;
      else if (p < 62) f = FUNC_INSERT;
      else if (p < 70) f = FUNC_REMOVE;
      else if (p < 94) f = FUNC_TICK;
      else if (p < 96) f = FUNC_CLEAR;
      else if (p < 98) f = FUNC_UNUSED_A;
      else f = FUNC_UNUSED_B;
      return make_req(f, pick_ip(), rand_mac());
   endfunction

   // ---------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------
   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   function automatic dir_row_type row(logic [2:0] f, logic [31:0] ip, logic [47:0] mac,
                                       bit typed, rsp_type want);
      dir_row_type d;
      d.cmd = make_req(f, ip, mac);
      d.typed = typed;
      d.want = want;
      return d;
   endfunction

   localparam logic [31:0] IP_ZERO = 32'h0;
   localparam logic [31:0] IP_ONES = 32'hFFFF_FFFF;
   localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

   dir_row_type directed[$];

   function automatic void add_row(dir_row_type d);
      directed = {directed, d};
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      rsp_type none;
      logic [15:0] cfg_timeout [5];
      logic [7:0]  cfg_tries   [5];
      logic [7:0]  cfg_retry   [5];
      none = rsp_word(KIND_HIT, '0, '0, '0, '0, 1'b0);
      long_hold_req = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_TIMEOUT;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.word = make_req(FUNC_LOOKUP, '0, '0);
      timeout_ticks = 16'd30;
      try_limit = 8'd5;
      retry_ticks = 8'd1;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         cache_valid[i] = 1'b0;
         cache_ip[i] = '0;
         cache_mac[i] = '0;
         cache_age[i] = '0;
      end
      for (int i = 0; i < REQUEST_SLOTS; i++) begin
         pend_valid[i] = 1'b0;
         pend_ip[i] = '0;
         pend_sent[i] = 1'b0;
         pend_tries[i] = '0;
         pend_since[i] = '0;
         pend_pkts[i] = '0;
      end
      // distinct pool addresses: slot number in the top byte, then all zeros and all ones in slots 0 and 1
      for (int i = 0; i < IP_POOL; i++) ip_pool[i] = {8'(i), 24'($urandom)};
      ip_pool[0] = IP_ZERO;
      ip_pool[1] = IP_ONES;

      // defaults after reset: timeout 30, 5 tries, retry every tick
      add_row(row(FUNC_LOOKUP, IP_ZERO, MAC_ONES, 1'b1,
                  rsp_word(KIND_MISS, IP_ZERO, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_LOOKUP, IP_ONES, '0, 1'b1,
                  rsp_word(KIND_MISS, IP_ONES, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_INSERT, IP_ONES, MAC_ONES, 1'b1,
                  rsp_word(KIND_INS_NONE, IP_ONES, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_LOOKUP, IP_ONES, '0, 1'b1,
                  rsp_word(KIND_HIT, IP_ONES, MAC_ONES, '0, '0, 1'b1)));
      add_row(row(FUNC_QUEUE, IP_ZERO, '0, 1'b1,
                  rsp_word(KIND_QNEW, IP_ZERO, '0, '0, 16'd1, 1'b1)));
      add_row(row(FUNC_QUEUE, IP_ZERO, MAC_ONES, 1'b1,
                  rsp_word(KIND_QOLD, IP_ZERO, '0, '0, 16'd2, 1'b1)));
      add_row(row(FUNC_INSERT, IP_ZERO, '0, 1'b1,
                  rsp_word(KIND_INS_WAIT, IP_ZERO, '0, '0, 16'd2, 1'b1)));
      // rewrite of a cached address keeps one entry
      add_row(row(FUNC_INSERT, IP_ONES, 48'h0123_4567_89AB, 1'b0, none));
      add_row(row(FUNC_LOOKUP, IP_ONES, '0, 1'b0, none));
      add_row(row(FUNC_TICK, '0, '0, 1'b1,
                  rsp_word(KIND_SEND, IP_ZERO, '0, 8'd1, 16'd2, 1'b1)));
      add_row(row(FUNC_TICK, IP_ONES, MAC_ONES, 1'b1,
                  rsp_word(KIND_SEND, IP_ZERO, '0, 8'd2, 16'd2, 1'b1)));
      add_row(row(FUNC_REMOVE, IP_ZERO, '0, 1'b1,
                  rsp_word(KIND_REMOVED, IP_ZERO, '0, 8'd2, 16'd2, 1'b1)));
      // remove of an address with no request
      add_row(row(FUNC_REMOVE, 32'h0A00_0005, '0, 1'b1,
                  rsp_word(KIND_REMOVED, 32'h0A00_0005, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_TICK, '0, '0, 1'b1, rsp_word(KIND_TICK, '0, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_CLEAR, IP_ONES, MAC_ONES, 1'b1,
                  rsp_word(KIND_CLEARED, '0, '0, '0, '0, 1'b1)));
      add_row(row(FUNC_UNUSED_A, IP_ONES, MAC_ONES, 1'b0, none));
      add_row(row(FUNC_UNUSED_B, '0, '0, 1'b0, none));
      add_row(row(FUNC_LOOKUP, IP_ONES, '0, 1'b1,
                  rsp_word(KIND_MISS, IP_ONES, '0, '0, '0, 1'b1)));

      // settings: defaults, low extremes, high extremes, mid, random
      cfg_timeout = '{16'd30, 16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(1, 65535))};
      cfg_tries   = '{8'd5, 8'd1, 8'hFF, 8'd3, 8'($urandom_range(1, 255))};
      cfg_retry   = '{8'd1, 8'd1, 8'hFF, 8'd2, 8'($urandom_range(1, 8))};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k]) send_word(directed[k].cmd, directed[k].typed, directed[k].want);

      for (int ph = 0; ph < 5; ph++) begin
         idle_until_drained();
         if (ph != 0) begin
            write_csr(CSR_TIMEOUT, cfg_timeout[ph]);
            write_csr(CSR_MAX_TRIES, 16'(cfg_tries[ph]));
            write_csr(CSR_RETRY, 16'(cfg_retry[ph]));
         end
         gaps_on = (ph % 2) == 1;
         if (ph == 2) begin
            // long receiver hold while words keep coming: the block backs up
            long_hold_req++;
            // then fill both tables past their depth
            for (int i = 0; i < CACHE_SLOTS + 2; i++)
               send_word(make_req(FUNC_INSERT, ip_pool[i], rand_mac()), 1'b0, none);
            for (int i = 0; i < REQUEST_SLOTS + 2; i++)
               send_word(make_req(FUNC_QUEUE, ip_pool[IP_POOL - 1 - i], '0), 1'b0, none);
            for (int i = 0; i < 3; i++) send_word(make_req(FUNC_TICK, '0, '0), 1'b0, none);
         end
         for (int i = 0; i < 56; i++) begin
            if (ph == 3 && i == 28) idle_until_drained();   // sender pause mid-phase
            send_word(rand_req(), 1'b0, none);
         end
      end

      req_ch.valid = 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: arp_cache_with_retry.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_if.sv
hw/rtl/arpc_csr.sv
hw/rtl/arpc_engine.sv
hw/rtl/arp_cache_with_retry.sv
sim/tb_arp_cache_with_retry.sv
